### design/assert_macros.svh
// Assertion macros used by the checker file of the cache lookup unit.
// Needs a clk and an arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define CHK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition, once seen, holds on the next edge.
`define CHK_HOLD(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

### design/sacl_pkg.sv
// Package of the set-associative cache lookup unit: config codes and types.
// No dependencies.
package sacl_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
	localparam logic [1:0] CFG_SET_BITS    = 2'd1;
	localparam logic [1:0] CFG_WAYS        = 2'd2;
	localparam logic [1:0] CFG_POLICY      = 2'd3;

	localparam int CFG_DATA_W = 4;
	localparam int SET_W      = 8;
	localparam int NW_W       = 5;
	localparam int OUT_DATA_W = 16;

	localparam logic [15:0] LFSR_MASK  = 16'hB400;
	localparam logic [15:0] LFSR_RESET = 16'h0001;

	// effective geometry after clamping
	typedef struct packed {
		logic [2:0]      ob;
		logic [3:0]      sb;
		logic [NW_W-1:0] nw;
		logic            rnd;
	} cfg_t;

endpackage

### design/sacl_queue.sv
// Two-entry queue between the block splitter and the lookup engine.
// No package dependencies.
module sacl_queue #(
	parameter int W = 70
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] rdata
);

	logic [W-1:0] entry_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign rdata     = entry_q[rp_q];

	// store incoming command
	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wp_q] <= wdata;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= ~wp_q;
			end
			if (pop && not_empty) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
		end
	end

endmodule

### design/sacl_front.sv
// Front end of the cache lookup unit: accepts an access and splits it into
// one command per cache block. Depends on sacl_pkg.
module sacl_front #(
	parameter int ADDR_WIDTH = 64,
	parameter int TW         = 61,
	parameter int CW         = 70
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sacl_pkg::cfg_t        cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ADDR_WIDTH-1:0] address,
	input  logic [7:0]            byte_count,
	output logic                  cmd_push,
	output logic [CW-1:0]         cmd_data,
	input  logic                  cmd_full
);

	logic                  busy_q;
	logic [ADDR_WIDTH-1:0] addr_q;
	logic [5:0]            left_q;

	logic [9:0]            bsize;
	logic [9:0]            start_off;
	logic [9:0]            span;
	logic [5:0]            blocks;
	logic [TW-1:0]         tag;
	logic [8:0]            set_mask;
	logic [sacl_pkg::SET_W-1:0] set_idx;
	logic                  last;

	assign in_ready = !busy_q;

	// number of blocks the access touches
	always_comb begin
		bsize     = 10'd1 << cfg.ob;
		start_off = 10'(address[6:0]) & (bsize - 10'd1);
		span      = start_off + 10'(byte_count) + bsize - 10'd1;
		blocks    = 6'(span >> cfg.ob);
	end

	// split current block address into set and tag
	always_comb begin
		set_mask = (9'd1 << cfg.sb) - 9'd1;
		set_idx  = 8'(addr_q >> cfg.ob) & set_mask[7:0];
		tag      = TW'(addr_q >> (5'(cfg.ob) + 5'(cfg.sb)));
		last     = (left_q == 6'd1);
	end

	assign cmd_push = busy_q && !cmd_full;
	assign cmd_data = {tag, set_idx, last};

	// step through the blocks of the access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			addr_q <= '0;
			left_q <= '0;
		end else if (!busy_q) begin
			if (in_valid && blocks != 6'd0) begin
				busy_q <= 1'b1;
				addr_q <= address;
				left_q <= blocks;
			end
		end else if (!cmd_full) begin
			addr_q <= addr_q + ADDR_WIDTH'(bsize);
			left_q <= left_q - 6'd1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

### design/sacl_back.sv
// Back end of the cache lookup unit: reads a set way by way, decides hit, fill or
// eviction, writes the set back in recency order or one random way in place. Depends on sacl_pkg.
module sacl_back #(
	parameter int MAX_WAYS = 8,
	parameter int DEPTH    = 2048,
	parameter int TW       = 61,
	parameter int CW       = 70
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sacl_pkg::cfg_t        cfg,
	output logic                  clearing,
	input  logic                  cmd_valid,
	input  logic [CW-1:0]         cmd_data,
	output logic                  cmd_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [sacl_pkg::OUT_DATA_W-1:0] out_data,
	output logic                  out_last
);

	localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WIW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int NW  = sacl_pkg::NW_W;

	localparam logic [2:0] ST_CLR    = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_MOD    = 3'd4;
	localparam logic [2:0] ST_WRITE  = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	// tag store with valid bit on top
	logic [TW:0]    mem [DEPTH];
	logic [TW:0]    rdata_q;
	logic           we;
	logic [IW-1:0]  waddr;
	logic [TW:0]    wdata;
	logic [IW-1:0]  raddr;

	logic [2:0]     state_q;
	logic [IW:0]    clr_q;
	logic [TW-1:0]  tag_q;
	logic [7:0]     set_q;
	logic           last_q;
	logic [IW-1:0]  base_q;
	logic [NW-1:0]  iss_q;
	logic           rv_q;
	logic [NW-1:0]  rw_q;
	logic           match_v_q;
	logic [NW-1:0]  match_q;
	logic           free_v_q;
	logic [NW-1:0]  free_q;
	logic [NW-1:0]  pos_q;
	logic           hit_q;
	logic           evict_q;
	logic           rnd_q;
	logic [NW-1:0]  rem_q;
	logic [3:0]     bit_q;
	logic [15:0]    lfsr_q;
	logic [TW-1:0]  buf_t_q [MAX_WAYS];
	logic           buf_v_q [MAX_WAYS];
	logic           ovalid_q;
	logic [sacl_pkg::OUT_DATA_W-1:0] odata_q;
	logic           olast_q;

	logic [NW:0]    rem_t;
	logic [NW-1:0]  rem_nx;
	logic [12:0]    base_prod;
	logic [WIW-1:0] prev_way;
	logic [15:0]    lfsr_nx;

	assign clearing  = (state_q == ST_CLR);
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;
	assign out_last  = olast_q;

	// helpers for remainder step, set base and LFSR advance
	always_comb begin
		rem_t     = {rem_q, lfsr_q[bit_q]};
		rem_nx    = (rem_t >= (NW+1)'(cfg.nw)) ? NW'(rem_t - (NW+1)'(cfg.nw)) : NW'(rem_t);
		base_prod = 13'(cmd_data[8:1]) * 13'(cfg.nw);
		prev_way  = WIW'(pos_q - NW'(1));
		lfsr_nx   = (lfsr_q >> 1) ^ (lfsr_q[0] ? sacl_pkg::LFSR_MASK : 16'h0000);
	end

	// memory port selection
	always_comb begin
		raddr = IW'(base_q + IW'(iss_q));
		we    = 1'b0;
		waddr = IW'(base_q + IW'(pos_q));
		wdata = {1'b1, tag_q};
		if (state_q == ST_CLR) begin
			we    = 1'b1;
			waddr = clr_q[IW-1:0];
			wdata = '0;
		end else if (state_q == ST_WRITE) begin
			we = 1'b1;
			if (pos_q != NW'(0) && !rnd_q) begin
				wdata = {buf_v_q[prev_way], buf_t_q[prev_way]};
			end
		end
	end

	// tag store write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// capture set contents as they stream in
	always_ff @(posedge clk) begin
		if (state_q == ST_READ && rv_q) begin
			buf_t_q[rw_q[WIW-1:0]] <= rdata_q[TW-1:0];
			buf_v_q[rw_q[WIW-1:0]] <= rdata_q[TW];
		end
	end

	// command payload
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			tag_q  <= cmd_data[CW-1:9];
			set_q  <= cmd_data[8:1];
			last_q <= cmd_data[0];
			base_q <= IW'(base_prod);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			iss_q     <= '0;
			rv_q      <= 1'b0;
			rw_q      <= '0;
			match_v_q <= 1'b0;
			match_q   <= '0;
			free_v_q  <= 1'b0;
			free_q    <= '0;
			pos_q     <= '0;
			hit_q     <= 1'b0;
			evict_q   <= 1'b0;
			rnd_q     <= 1'b0;
			rem_q     <= '0;
			bit_q     <= '0;
			lfsr_q    <= sacl_pkg::LFSR_RESET;
			ovalid_q  <= 1'b0;
			odata_q   <= '0;
			olast_q   <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + (IW+1)'(1);
					if (clr_q == (IW+1)'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						iss_q     <= '0;
						rv_q      <= 1'b0;
						match_v_q <= 1'b0;
						free_v_q  <= 1'b0;
						rnd_q     <= 1'b0;
						hit_q     <= 1'b0;
						evict_q   <= 1'b0;
						state_q   <= ST_READ;
					end
				end
				ST_READ: begin
					// issue one way per cycle
					rv_q <= (iss_q < cfg.nw);
					rw_q <= iss_q;
					if (iss_q < cfg.nw) begin
						iss_q <= iss_q + NW'(1);
					end
					// classify the way that came back
					if (rv_q) begin
						if (rdata_q[TW]) begin
							if (rdata_q[TW-1:0] == tag_q) begin
								match_v_q <= 1'b1;
								match_q   <= rw_q;
							end
						end else if (!free_v_q) begin
							free_v_q <= 1'b1;
							free_q   <= rw_q;
						end
						if (rw_q == cfg.nw - NW'(1)) begin
							rv_q    <= 1'b0;
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (match_v_q) begin
						hit_q   <= 1'b1;
						pos_q   <= match_q;
						state_q <= ST_WRITE;
					end else if (free_v_q) begin
						pos_q   <= free_q;
						state_q <= ST_WRITE;
					end else if (cfg.rnd) begin
						evict_q <= 1'b1;
						rem_q   <= '0;
						bit_q   <= 4'd15;
						state_q <= ST_MOD;
					end else begin
						evict_q <= 1'b1;
						pos_q   <= cfg.nw - NW'(1);
						state_q <= ST_WRITE;
					end
				end
				ST_MOD: begin
					// restoring remainder, one LFSR bit per cycle
					rem_q <= rem_nx;
					bit_q <= bit_q - 4'd1;
					if (bit_q == 4'd0) begin
						pos_q   <= rem_nx;
						rnd_q   <= 1'b1;
						lfsr_q  <= lfsr_nx;
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					// shift ways down toward the front, or overwrite in place
					if (pos_q == NW'(0) || rnd_q) begin
						state_q <= ST_OUT;
					end else begin
						pos_q <= pos_q - NW'(1);
					end
				end
				ST_OUT: begin
					if (!ovalid_q || out_ready) begin
						ovalid_q <= 1'b1;
						odata_q  <= {5'd0, set_q, evict_q, !hit_q, hit_q};
						olast_q  <= last_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### design/set_assoc_cache_lookup_unit.sv
// Top level of the set-associative cache lookup unit: config registers,
// splitter front end, command queue and lookup back end. Depends on sacl_pkg.
//
// Channel   Dir  Contents
// s_axis    in   tdata: address, byte_count (packed from bit 0, zero padded)
// m_axis    out  tdata: hit, miss, eviction, set_index; tlast: last_block
// cfg       in   cfg_we, cfg_index, cfg_data; no read-back
//
// The lookup engine handles one block at a time (one tag store port, read then
// shifted back one way per cycle); a random eviction first works out the way
// remainder from the LFSR. The splitter takes a new access once the previous
// one is fully queued. After reset the tag store is cleared with s_tready low.
// A stalled m_tready holds the lookup engine once its output register is full.
module set_assoc_cache_lookup_unit #(
	parameter int MAX_WAYS   = 8,
	parameter int MAX_SETS   = 256,
	parameter int ADDR_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [((ADDR_WIDTH + 8 + 7) / 8) * 8 - 1:0] s_tdata, // address, byte_count
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sacl_pkg::OUT_DATA_W-1:0] m_tdata, // hit, miss, eviction, set_index
	output logic                          m_tlast
);

	localparam int TW    = ADDR_WIDTH - 3;
	localparam int CW    = TW + sacl_pkg::SET_W + 1;
	localparam int DEPTH = MAX_WAYS * MAX_SETS;
	localparam int SMAX0 = $clog2(MAX_SETS + 1) - 1;
	localparam int SMAX  = (SMAX0 > 8) ? 8 : SMAX0;

	logic [2:0]     offset_bits_q;
	logic [3:0]     set_bits_q;
	logic [3:0]     ways_q;
	logic           policy_q;
	sacl_pkg::cfg_t cfg;

	logic           front_ready;
	logic           clearing;
	logic           cmd_push;
	logic [CW-1:0]  cmd_wdata;
	logic           cmd_full;
	logic           cmd_pop;
	logic           cmd_valid;
	logic [CW-1:0]  cmd_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= 3'd6;
			set_bits_q    <= 4'd4;
			ways_q        <= 4'd4;
			policy_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				sacl_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data[2:0];
				sacl_pkg::CFG_SET_BITS:    set_bits_q    <= cfg_data[3:0];
				sacl_pkg::CFG_WAYS:        ways_q        <= cfg_data[3:0];
				sacl_pkg::CFG_POLICY:      policy_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// clamp geometry to the supported range
	always_comb begin
		cfg.ob  = (offset_bits_q < 3'd3) ? 3'd3 : offset_bits_q;
		cfg.sb  = (set_bits_q > 4'(SMAX)) ? 4'(SMAX) : set_bits_q;
		cfg.nw  = (ways_q == 4'd0) ? sacl_pkg::NW_W'(1) :
			(5'(ways_q) > 5'(MAX_WAYS)) ? sacl_pkg::NW_W'(MAX_WAYS) : 5'(ways_q);
		cfg.rnd = policy_q;
	end

	assign s_tready = front_ready && !clearing;

	sacl_front #(
		.ADDR_WIDTH(ADDR_WIDTH),
		.TW(TW),
		.CW(CW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(s_tvalid && !clearing),
		.in_ready(front_ready),
		.address(s_tdata[ADDR_WIDTH-1:0]),
		.byte_count(s_tdata[ADDR_WIDTH+7:ADDR_WIDTH]),
		.cmd_push(cmd_push),
		.cmd_data(cmd_wdata),
		.cmd_full(cmd_full)
	);

	sacl_queue #(
		.W(CW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.wdata(cmd_wdata),
		.full(cmd_full),
		.pop(cmd_pop),
		.not_empty(cmd_valid),
		.rdata(cmd_rdata)
	);

	sacl_back #(
		.MAX_WAYS(MAX_WAYS),
		.DEPTH(DEPTH),
		.TW(TW),
		.CW(CW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.clearing(clearing),
		.cmd_valid(cmd_valid),
		.cmd_data(cmd_rdata),
		.cmd_pop(cmd_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(m_tdata),
		.out_last(m_tlast)
	);

endmodule

### design/sacl_checker.sv
// Port-level checker for the cache lookup unit, bound to the top level.
// Depends on assert_macros.svh and sacl_pkg.
`include "assert_macros.svh"

module sacl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [sacl_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                          m_tlast
);

	// a stalled result stays offered
	`CHK_HOLD(a_valid_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

	// a stalled result keeps its payload
	`CHK_HOLD(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "payload changed while stalled")

	// exactly one of hit and miss per block
	`CHK_ASSERT(a_hit_xor_miss, m_tvalid |-> (m_tdata[0] ^ m_tdata[1]), "hit and miss not exclusive")

	// an eviction only comes with a miss
	`CHK_ASSERT(a_evict_miss, (m_tvalid && m_tdata[2]) |-> (m_tdata[1] && !m_tdata[0]), "eviction without miss")

endmodule

bind set_assoc_cache_lookup_unit sacl_checker u_sacl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast)
);

### sim/set_assoc_cache_lookup_unit_tb.sv
// Testbench of the set-associative cache lookup unit: directed table, then random accesses
// over several cache geometries, each result checked against a behavioral cache model.
// Depends on sacl_pkg and set_assoc_cache_lookup_unit.
`timescale 1ns / 100ps

module set_assoc_cache_lookup_unit_tb;

	localparam int N_WAYS    = 8;
	localparam int N_SETS    = 256;
	localparam int DEPTH     = N_WAYS * N_SETS;
	localparam int DRAIN_CYC = 400;
	localparam int LIMIT     = 3000000;

	typedef struct {
		logic       hit;
		logic       miss;
		logic       evict;
		logic [7:0] set_idx;
		logic       last;
	} block_res_t;

	typedef struct {
		logic [63:0] addr;
		logic [7:0]  cnt;
		bit          known;
		logic        hit;
		logic        miss;
		logic        evict;
		logic [7:0]  set_idx;
	} access_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;   // address[63:0], byte_count[71:64]
	logic        m_tvalid;
	logic        m_tready;
	logic [sacl_pkg::OUT_DATA_W-1:0] m_tdata; // hit, miss, eviction, set_index[10:3], zero pad
	logic        m_tlast;

	// cache model state
	logic [63:0] model_tag [DEPTH];
	bit          model_valid [DEPTH];
	logic [15:0] model_lfsr;
	logic [2:0]  reg_ob;
	logic [3:0]  reg_sb;
	logic [3:0]  reg_ways;
	logic        reg_policy;

	block_res_t  pending_blocks[$];
	int          errors;
	int          cycles;
	int          accesses_sent;
	int          blocks_seen;
	int          hits_seen;
	int          evicts_seen;
	int          hold_req;
	int          hold_left;
	int          rx_mode;
	logic [12:0] rx_pattern;
	int          rx_phase;
	bit          tx_gaps;
	int          burst_left;

	set_assoc_cache_lookup_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #4 clk = ~clk;

	// Shift ways 0..pos-1 down one and put the tag at the front.
	function automatic void promote(int base, int pos, logic [63:0] tag);
		for (int c = pos; c > 0; c--) begin
			model_tag[base + c]   = model_tag[base + c - 1];
			model_valid[base + c] = model_valid[base + c - 1];
		end
		model_tag[base]   = tag;
		model_valid[base] = 1'b1;
	endfunction

	// Walk the blocks of one access, update the cache model, queue the block results.
	function automatic void lookup_access(logic [63:0] addr, logic [7:0] cnt);
		int ob, sb, nw, blocks, base, set, hit_way, free_way, w;
		logic [63:0] bsize, a, tag;
		block_res_t r;
		ob = (reg_ob < 3) ? 3 : reg_ob;
		sb = (reg_sb > 8) ? 8 : reg_sb;
		nw = (reg_ways == 0) ? 1 : ((reg_ways > N_WAYS) ? N_WAYS : reg_ways);
		if (cnt == 0)
			return;
		bsize  = 64'd1 << ob;
		blocks = (int'(addr & (bsize - 1)) + int'(cnt) + int'(bsize) - 1) >> ob;
		for (int k = 0; k < blocks; k++) begin
			a        = addr + 64'(k) * bsize;
			set      = int'((a >> ob) & ((64'd1 << sb) - 1));
			tag      = a >> (ob + sb);
			base     = set * nw;
			hit_way  = -1;
			free_way = -1;
			for (int b = 0; b < nw; b++) begin
				if (model_valid[base + b]) begin
					if (model_tag[base + b] == tag)
						hit_way = b;
				end else if (free_way < 0) begin
					free_way = b;
				end
			end
			r = '{hit: 1'b0, miss: 1'b1, evict: 1'b0, set_idx: set[7:0], last: k == blocks - 1};
			if (hit_way >= 0) begin
				r.hit  = 1'b1;
				r.miss = 1'b0;
				promote(base, hit_way, tag);
			end else if (free_way >= 0) begin
				promote(base, free_way, tag);
			end else begin
				r.evict = 1'b1;
				if (reg_policy) begin
					w = int'(model_lfsr) % nw;
					model_lfsr = model_lfsr[0] ? ((model_lfsr >> 1) ^ 16'hB400) : (model_lfsr >> 1);
					model_tag[base + w]   = tag;
					model_valid[base + w] = 1'b1;
				end else begin
					promote(base, nw - 1, tag);
				end
			end
			pending_blocks.push_back(r);
		end
	endfunction

	// Write one register; the caller lowers cfg_we after the last write.
	task automatic write_reg(logic [1:0] idx, logic [3:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			sacl_pkg::CFG_OFFSET_BITS: reg_ob     = val[2:0];
			sacl_pkg::CFG_SET_BITS:    reg_sb     = val;
			sacl_pkg::CFG_WAYS:        reg_ways   = val;
			sacl_pkg::CFG_POLICY:      reg_policy = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Wait for every result, then let a trailing empty access settle.
	task automatic drain();
		while (pending_blocks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic configure(logic [3:0] ob, logic [3:0] sb, logic [3:0] nw, logic [3:0] pol);
		drain();
		write_reg(sacl_pkg::CFG_OFFSET_BITS, ob);
		write_reg(sacl_pkg::CFG_SET_BITS, sb);
		write_reg(sacl_pkg::CFG_WAYS, nw);
		write_reg(sacl_pkg::CFG_POLICY, pol);
		cfg_we <= 1'b0;
	endtask

	// Offer one access; hold it until the transaction completes.
	task automatic send_access(access_row_t row);
		int gap;
		block_res_t r;
		gap = 0;
		if (tx_gaps) begin
			if (burst_left == 0) begin
				gap        = $urandom_range(1, 12);
				burst_left = $urandom_range(1, 10);
			end
			burst_left--;
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {row.cnt, row.addr};
		do @(posedge clk); while (!s_tready);
		lookup_access(row.addr, row.cnt);
		accesses_sent++;
		if (row.known) begin
			r = '{hit: row.hit, miss: row.miss, evict: row.evict, set_idx: row.set_idx,
				last: 1'b1};
			pending_blocks[pending_blocks.size() - 1] = r;
		end
	endtask

	function automatic access_row_t random_access(int mode_sel);
		access_row_t row;
		row = '{default: '0};
		case ($urandom_range(0, 9))
			0, 1: row.addr = {$urandom(), $urandom()};
			2:    row.addr = 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(0, 255));
			default: row.addr = 64'($urandom_range(0, 15)) << (mode_sel + 10)
				| 64'($urandom_range(0, 2047));
		endcase
		case ($urandom_range(0, 15))
			0:       row.cnt = 8'd255;
			1:       row.cnt = 8'($urandom_range(0, 255));
			default: row.cnt = 8'($urandom_range(1, 24));
		endcase
		return row;
	endfunction

	// Free-running cycle limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: long hold on request, otherwise ready, random, or a rotating pattern.
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		rx_phase = (rx_phase + 1) % 13;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= rx_pattern[rx_phase];
			endcase
		end
	end

	// Compare each result transaction against the oldest expected block.
	always @(posedge clk) begin
		block_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			blocks_seen++;
			if (pending_blocks.size() == 0) begin
				$error("unexpected result transaction: tdata %h tlast %b", m_tdata, m_tlast);
				errors++;
			end else begin
				e = pending_blocks.pop_front();
				if (m_tdata[0] !== e.hit) begin
					$error("hit: expected %b, got %b", e.hit, m_tdata[0]);
					errors++;
				end
				if (m_tdata[1] !== e.miss) begin
					$error("miss: expected %b, got %b", e.miss, m_tdata[1]);
					errors++;
				end
				if (m_tdata[2] !== e.evict) begin
					$error("eviction: expected %b, got %b", e.evict, m_tdata[2]);
					errors++;
				end
				if (m_tdata[10:3] !== e.set_idx) begin
					$error("set_index: expected %0d, got %0d", e.set_idx, m_tdata[10:3]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last_block: expected %b, got %b", e.last, m_tlast);
					errors++;
				end
				hits_seen   += e.hit;
				evicts_seen += e.evict;
			end
		end
	end

	initial begin
		access_row_t directed [] = '{
			'{64'h0,    8'd1,  1, 0, 1, 0, 8'd0},
			'{64'h0,    8'd1,  1, 1, 0, 0, 8'd0},
			'{64'h40,   8'd64, 1, 0, 1, 0, 8'd1},
			'{64'h0,    8'd0,  0, 0, 0, 0, 8'd0},
			'{64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 0, 0, 0, 0, 8'd0},
			'{64'h3F,   8'd2,  0, 0, 0, 0, 8'd0},
			'{64'h8000_0000_0000_0000, 8'd255, 0, 0, 0, 0, 8'd0},
			'{64'h400,  8'd1,  1, 0, 1, 0, 8'd0},
			'{64'h800,  8'd1,  1, 0, 1, 0, 8'd0},
			'{64'hC00,  8'd1,  1, 0, 1, 1, 8'd0},
			'{64'h1000, 8'd1,  1, 0, 1, 1, 8'd0},
			'{64'h0,    8'd1,  1, 0, 1, 1, 8'd0},
			'{64'h1000, 8'd1,  1, 1, 0, 0, 8'd0},
			'{64'h5555_AAAA_5555_AAAA, 8'd128, 0, 0, 0, 0, 8'd0},
			'{64'hAAAA_5555_AAAA_5555, 8'd17,  0, 0, 0, 0, 8'd0}
		};
		// geometry per phase: offset_bits, set_bits, ways, policy
		logic [3:0] phase_cfg [7][4] = '{
			'{4'd3, 4'd0,  4'd1,  4'd0},
			'{4'd7, 4'd8,  4'd8,  4'd1},
			'{4'd0, 4'd15, 4'd0,  4'd1},
			'{4'd4, 4'd2,  4'd15, 4'd0},
			'{4'd5, 4'd3,  4'd2,  4'd1},
			'{4'd3, 4'd1,  4'd8,  4'd1},
			'{4'd6, 4'd8,  4'd4,  4'd0}
		};
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sacl_pkg::CFG_OFFSET_BITS;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		errors = 0;
		cycles = 0;
		accesses_sent = 0;
		blocks_seen = 0;
		hits_seen = 0;
		evicts_seen = 0;
		hold_req = 0;
		hold_left = 0;
		rx_mode = 0;
		rx_pattern = 13'b1011001110101;
		rx_phase = 0;
		tx_gaps = 1'b0;
		burst_left = 0;
		for (int i = 0; i < DEPTH; i++) begin
			model_tag[i]   = '0;
			model_valid[i] = 1'b0;
		end
		model_lfsr = sacl_pkg::LFSR_RESET;
		reg_ob = 3'd6;
		reg_sb = 4'd4;
		reg_ways = 4'd4;
		reg_policy = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed table under the reset geometry, no idling
		foreach (directed[i])
			send_access(directed[i]);
		s_tvalid <= 1'b0;

		// random phases over each geometry with varying idling
		for (int p = 0; p < 7; p++) begin
			configure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
			rx_mode    = p % 3;
			rx_pattern = 13'($urandom());
			tx_gaps    = (p % 2) == 1;
			if (p == 1)
				hold_req = 1500;
			for (int n = 0; n < 14; n++) begin
				send_access(random_access(p % 3));
				// pause until every result is in
				if (p == 3 && n == 6) begin
					s_tvalid <= 1'b0;
					while (pending_blocks.size() != 0)
						@(posedge clk);
				end
			end
			s_tvalid <= 1'b0;
		end

		drain();
		$display("Covered %0d accesses and %0d block results (%0d hits, %0d evictions)",
			accesses_sent, blocks_seen, hits_seen, evicts_seen);
		$display("over 8 geometries with LRU and random replacement and output back-pressure.");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
